// ----- rtl/lbe_pkg.sv -----
// ----------------------------------------------------------------------------
// lbe_pkg
// Types, node constants and inverse denominators for the Lagrange basis unit.
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int unsigned TableDepth = 35;
  localparam int unsigned TableOrder = 7;
  localparam logic signed [31:0] OneQ24 = 32'sd16777216;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD_INIT,
    ST_MUL,
    ST_ACC,
    ST_FINAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;       // capture transaction, clear indices
    logic       prod_init;  // product := 1.0
    logic       mul_step;   // product *= (x - x_l)
    logic       acc;        // sum += product
    logic       fin;        // result := v * W
    logic       emit;       // strobe result
    logic       l_next;
    logic       i_next;
  } ctrl_t;

  typedef struct packed {
    logic action;
    logic l_skip;   // l == i, or l == k when action is set
    logic l_done;   // l == n
    logic k_done;   // k == n, or k + 1 == n when i == n
    logic i_done;   // i == n
  } status_t;

  typedef logic [TableDepth-1:0][31:0] inv_tbl_t;

  function automatic logic [5:0] table_base(input logic [2:0] n);
    logic [5:0] nn;
    nn = {3'd0, n};
    return 6'(((nn - 6'd1) * (nn + 6'd2)) >> 1);
  endfunction

  function automatic logic signed [31:0] node_rom(input logic [5:0] a);
    logic signed [31:0] r;
    case (a)
      6'd0, 6'd2, 6'd5, 6'd9, 6'd14, 6'd20, 6'd27: r = -OneQ30;
      6'd1, 6'd4, 6'd8, 6'd13, 6'd19, 6'd26, 6'd34: r = OneQ30;
      6'd3, 6'd11, 6'd23: r = 32'sd0;
      6'd6:  r = -32'sd480191942;
      6'd7:  r = 32'sd480191942;
      6'd10: r = -32'sd702929026;
      6'd12: r = 32'sd702929026;
      6'd15: r = -32'sd821471899;
      6'd16: r = -32'sd306265009;
      6'd17: r = 32'sd306265009;
      6'd18: r = 32'sd821471899;
      6'd21: r = -32'sd891446121;
      6'd22: r = -32'sd503422559;
      6'd24: r = 32'sd503422559;
      6'd25: r = 32'sd891446121;
      6'd28: r = -32'sd936023857;
      6'd29: r = -32'sd635333232;
      6'd30: r = -32'sd224733324;
      6'd31: r = 32'sd224733324;
      6'd32: r = 32'sd635333232;
      6'd33: r = 32'sd936023857;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Inverse denominator W_i for table entry a (Q8.24), evaluated at
  // elaboration only to fill the constant table below.
  function automatic logic signed [31:0] inv_den(input logic [5:0] a);
    logic [63:0] prod;
    logic [63:0] w;
    logic [63:0] m;
    logic [63:0] num;
    logic [63:0] rem;
    logic signed [33:0] d;
    logic neg;
    int unsigned n;
    int unsigned base;
    int unsigned i;
    prod = 64'd1 << 28;
    neg = 1'b0;
    n = 1;
    for (int unsigned t = 1; t <= TableOrder; t++) begin
      if (int'(a) >= int'(((t - 1) * (t + 2)) >> 1)) n = t;
    end
    base = ((n - 1) * (n + 2)) >> 1;
    i = int'(a) - base;
    for (int unsigned p = 0; p <= TableOrder; p++) begin
      if (p <= n && p != i) begin
        d = 34'(node_rom(a)) - 34'(node_rom(6'(base + p)));
        if (d < 0) begin
          neg = ~neg;
          m = 64'(-d);
        end else begin
          m = 64'(d);
        end
        prod = (prod * (m >> 2)) >> 28;
      end
    end
    if (prod == 64'd0) begin
      w = 64'h7FFF_FFFF;
    end else begin
      // rounded quotient by restoring long division
      num = (64'd1 << 52) + (prod >> 1);
      rem = '0;
      w   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= prod) begin
          rem  = rem - prod;
          w[b] = 1'b1;
        end
      end
    end
    if (w > 64'h7FFF_FFFF) w = 64'h7FFF_FFFF;
    return neg ? -$signed(w[31:0]) : $signed(w[31:0]);
  endfunction

  function automatic inv_tbl_t build_inv_den();
    inv_tbl_t tbl;
    for (int unsigned a = 0; a < TableDepth; a++) tbl[a] = inv_den(6'(a));
    return tbl;
  endfunction

  localparam inv_tbl_t InvDenTbl = build_inv_den();

endpackage

// ----- rtl/lagrange_basis_eval_unit.sv -----
// ----------------------------------------------------------------------------
// lagrange_basis_eval_unit
// Lagrange basis values or derivatives on Gauss-Lobatto nodes, one result
// per node, computed on a single shared multiplier.
// ----------------------------------------------------------------------------
// Busy stays high from acceptance until the final node has been processed, in
// basis and derivative mode alike; the last result strobes in the first cycle
// with busy low. The shared multiplier takes one factor per cycle; a new
// transaction is accepted once busy is low.
// Results strobe for one cycle each; the receiver cannot stall.
// Reset clears the sequencer and strobe; the node ROM is constant.
module lagrange_basis_eval_unit #(
  parameter int unsigned MAX_ORDER = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic signed [31:0] coord_i,
  input  logic [2:0]         order_i,
  output logic               strobe,
  output logic signed [31:0] value_o,
  output logic [2:0]         node_index_o,
  output logic               last_o,
  output logic               saturated_o
);

  lbe_pkg::ctrl_t   ctrl;
  lbe_pkg::status_t status;

  lbe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .valid_order_i (order_i != 3'd0),
    .status_i      (status),
    .ctrl_o        (ctrl),
    .busy_o        (busy)
  );

  lbe_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .action_i     (action_i),
    .coord_i      (coord_i),
    .order_i      (order_i),
    .status_o     (status),
    .done_o       (strobe),
    .value_o      (value_o),
    .node_index_o (node_index_o),
    .last_o       (last_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ----- rtl/lbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbe_ctrl
// Sequencer walking nodes i, partial terms k and factors l.
// ----------------------------------------------------------------------------
module lbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              valid_order_i,
  input  lbe_pkg::status_t  status_i,
  output lbe_pkg::ctrl_t    ctrl_o,
  output logic              busy_o
);

  lbe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lbe_pkg::ST_IDLE: begin
        if (start_i && valid_order_i) state_d = lbe_pkg::ST_PROD_INIT;
      end
      lbe_pkg::ST_PROD_INIT: state_d = lbe_pkg::ST_MUL;
      lbe_pkg::ST_MUL: begin
        if (status_i.l_done) begin
          state_d = status_i.action ? lbe_pkg::ST_ACC : lbe_pkg::ST_FINAL;
        end
      end
      lbe_pkg::ST_ACC: begin
        if (status_i.k_done) state_d = lbe_pkg::ST_FINAL;
        else state_d = lbe_pkg::ST_PROD_INIT;
      end
      lbe_pkg::ST_FINAL: state_d = lbe_pkg::ST_EMIT;
      lbe_pkg::ST_EMIT: begin
        if (status_i.i_done) state_d = lbe_pkg::ST_IDLE;
        else state_d = lbe_pkg::ST_PROD_INIT;
      end
      default: state_d = lbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      lbe_pkg::ST_IDLE: begin
        ctrl_o.load = start_i && valid_order_i;
      end
      lbe_pkg::ST_PROD_INIT: ctrl_o.prod_init = 1'b1;
      lbe_pkg::ST_MUL: begin
        ctrl_o.mul_step = ~status_i.l_skip;
        ctrl_o.l_next   = 1'b1;
      end
      lbe_pkg::ST_ACC: begin
        ctrl_o.acc = 1'b1;
      end
      lbe_pkg::ST_FINAL: ctrl_o.fin = 1'b1;
      lbe_pkg::ST_EMIT: begin
        ctrl_o.emit   = 1'b1;
        ctrl_o.i_next = 1'b1;
      end
      default: ctrl_o = '0;
    endcase
  end

  assign busy_o = (state_q != lbe_pkg::ST_IDLE);

endmodule

// ----- rtl/lbe_datapath.sv -----
// ----------------------------------------------------------------------------
// lbe_datapath
// Shared multiplier, product and sum registers, node and W lookup.
// ----------------------------------------------------------------------------
module lbe_datapath #(
  parameter int unsigned MAX_ORDER = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbe_pkg::ctrl_t     ctrl_i,
  input  logic               action_i,
  input  logic signed [31:0] coord_i,
  input  logic [2:0]         order_i,
  output lbe_pkg::status_t   status_o,
  output logic               done_o,
  output logic signed [31:0] value_o,
  output logic [2:0]         node_index_o,
  output logic               last_o,
  output logic               saturated_o
);

  localparam logic [2:0] MaxN =
    (MAX_ORDER > lbe_pkg::TableOrder) ? 3'(lbe_pkg::TableOrder) : 3'(MAX_ORDER);

  logic               action_q;
  logic signed [31:0] x_q;
  logic [2:0]         n_q;
  logic [5:0]         base_q;
  logic [2:0]         i_q, k_q, l_q;
  logic signed [31:0] prod_q, sum_q;
  logic               sat_q;
  logic               valid_q;
  logic signed [31:0] value_q;
  logic [2:0]         idx_q;
  logic               last_q, satout_q;

  logic [2:0]         n_in;
  logic signed [32:0] diff;
  logic signed [65:0] mul;
  logic signed [65:0] shr;
  logic signed [32:0] acc_sum;
  logic signed [31:0] w;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic [4:0]         sh;

  assign n_in = (order_i > MaxN) ? MaxN : order_i;
  assign diff = 33'(x_q) - 33'(lbe_pkg::node_rom(base_q + 6'(l_q)));
  assign w    = lbe_pkg::InvDenTbl[base_q + 6'(i_q)];
  assign mul_a = ctrl_i.fin ? (action_q ? sum_q : prod_q) : prod_q;
  assign mul_b = ctrl_i.fin ? 33'(w) : diff;
  assign sh    = ctrl_i.fin ? 5'd24 : 5'd30;
  assign mul   = 66'(mul_a) * 66'(mul_b);
  assign shr   = mul >>> sh;
  assign acc_sum = 33'(sum_q) + 33'(prod_q);

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic ovf66(input logic signed [65:0] v);
    return (v > 66'sh7FFF_FFFF) || (v < -66'sh8000_0000);
  endfunction

  assign status_o.action = action_q;
  assign status_o.l_skip = (l_q == i_q) || (action_q && l_q == k_q);
  assign status_o.l_done = (l_q == n_q);
  assign status_o.k_done = (k_q == n_q) ||
                           ((k_q + 3'd1 == n_q) && (n_q == i_q));
  assign status_o.i_done = (i_q == n_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      action_q <= action_i;
      x_q      <= coord_i;
      n_q      <= n_in;
      base_q   <= lbe_pkg::table_base(n_in);
      i_q      <= 3'd0;
      k_q      <= (3'd0 == 3'd0) ? 3'd1 : 3'd0;
      sum_q    <= '0;
      sat_q    <= 1'b0;
    end
    if (ctrl_i.prod_init) begin
      prod_q <= lbe_pkg::OneQ24;
      l_q    <= 3'd0;
    end
    if (ctrl_i.mul_step) begin
      prod_q <= sat66(shr);
      if (ovf66(shr)) sat_q <= 1'b1;
    end
    if (ctrl_i.l_next && !status_o.l_done) l_q <= l_q + 3'd1;
    if (ctrl_i.acc) begin
      if (acc_sum > 33'sh7FFF_FFFF) begin
        sum_q <= 32'sh7FFF_FFFF; sat_q <= 1'b1;
      end else if (acc_sum < -33'sh8000_0000) begin
        sum_q <= 32'sh8000_0000; sat_q <= 1'b1;
      end else begin
        sum_q <= acc_sum[31:0];
      end
      if (k_q + 3'd1 == i_q) k_q <= k_q + 3'd2;
      else k_q <= k_q + 3'd1;
    end
    if (ctrl_i.fin) begin
      value_q  <= sat66(shr);
      satout_q <= sat_q | ovf66(shr);
      idx_q    <= i_q;
      last_q   <= (i_q == n_q);
    end
    if (ctrl_i.i_next) begin
      i_q   <= i_q + 3'd1;
      k_q   <= (i_q + 3'd1 == 3'd0) ? 3'd1 : 3'd0;
      sum_q <= '0;
      sat_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit;
    end
  end

  assign done_o       = valid_q;
  assign value_o      = value_q;
  assign node_index_o = idx_q;
  assign last_o       = last_q;
  assign saturated_o  = satout_q;

endmodule
